@@ rtl/core/sld_pkg.sv @@
// shared types and constants for the sync word / length deframer
// no dependencies; imported by sld_parser, sld_outq, sync_length_deframer_top and the testbench
package sld_pkg;

	localparam logic [7:0] SYNC_FIRST_RST  = 8'hEB;
	localparam logic [7:0] SYNC_SECOND_RST = 8'h90;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

	// output queue: up to two beats pushed per byte, one popped per unstalled cycle
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} beat_t;

	typedef struct packed {
		logic [1:0] count;
		beat_t      b0;
		beat_t      b1;
	} parse_res_t;

endpackage

@@ rtl/core/sync_length_deframer_top.sv @@
// sync word / length deframer, top level: config registers, parser and output queue
// beats of an accepted byte are queued at its edge and leave after any older beats
// throughput: one byte per cycle in, one beat per cycle out while out_stall is low;
// a four-beat queue absorbs the two-beat sync burst; input stalls at three or more
// reset: async active low; hunting, queue empty, sync word back to EB 90
// depends on sld_pkg, sld_parser, sld_outq
module sync_length_deframer_top import sld_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           in_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_byte,
	output logic                 frame_first,
	output logic                 frame_last,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic [7:0] sync_first_q;
	logic [7:0] sync_second_q;
	logic       accept;
	logic       full;
	parse_res_t res;
	beat_t      head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				CFG_SYNC_SECOND: sync_second_q <= cfg_data;
			endcase
		end
	end

	assign in_stall = full;
	assign accept   = in_valid && !full;

	sld_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (in_byte),
		.sync_first  (sync_first_q),
		.sync_second (sync_second_q),
		.res         (res)
	);

	sld_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign out_byte    = head.data;
	assign frame_first = head.first;
	assign frame_last  = head.last;

endmodule

@@ rtl/core/sld_parser.sv @@
// frame parser: sync hunt, length capture, payload count, one byte per accept cycle
// depends on sld_pkg
module sld_parser import sld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic [7:0] sync_first,
	input  logic [7:0] sync_second,
	output parse_res_t res
);

	localparam logic [1:0] PH_HUNT    = 2'd0;
	localparam logic [1:0] PH_LEN_LO  = 2'd1;
	localparam logic [1:0] PH_LEN_HI  = 2'd2;
	localparam logic [1:0] PH_PAYLOAD = 2'd3;

	logic [1:0]  phase_q, phase_d;
	logic        saw_q, saw_d;
	logic [7:0]  len_lo_q, len_lo_d;
	logic [15:0] remain_q, remain_d;
	logic [15:0] len_full;
	logic [15:0] remain_dec;
	parse_res_t  res_c;

	assign len_full   = {in_byte, len_lo_q};
	assign remain_dec = (remain_q != 16'd0) ? remain_q - 16'd1 : remain_q;

	always_comb begin
		phase_d  = phase_q;
		saw_d    = saw_q;
		len_lo_d = len_lo_q;
		remain_d = remain_q;
		res_c    = '0;
		unique case (phase_q)
			PH_LEN_LO: begin
				len_lo_d      = in_byte;
				phase_d       = PH_LEN_HI;
				res_c.count   = 2'd1;
				res_c.b0.data = in_byte;
			end
			PH_LEN_HI: begin
				res_c.count   = 2'd1;
				res_c.b0.data = in_byte;
				remain_d      = len_full;
				if (len_full == 16'd0) begin
					// empty frame ends on the length high byte
					phase_d       = PH_HUNT;
					res_c.b0.last = 1'b1;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				remain_d      = remain_dec;
				res_c.count   = 2'd1;
				res_c.b0.data = in_byte;
				if (remain_dec == 16'd0) begin
					phase_d       = PH_HUNT;
					res_c.b0.last = 1'b1;
				end
			end
			PH_HUNT: begin
				// second-byte match wins over a new first-byte match
				if (saw_q && in_byte == sync_second) begin
					saw_d          = 1'b0;
					phase_d        = PH_LEN_LO;
					res_c.count    = 2'd2;
					res_c.b0.data  = sync_first;
					res_c.b0.first = 1'b1;
					res_c.b1.data  = in_byte;
				end else begin
					saw_d = (in_byte == sync_first);
				end
			end
		endcase
	end

	always_comb begin
		res = res_c;
		if (!accept) begin
			res.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			saw_q    <= 1'b0;
			len_lo_q <= 8'd0;
			remain_q <= 16'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			saw_q    <= saw_d;
			len_lo_q <= len_lo_d;
			remain_q <= remain_d;
		end
	end

endmodule

@@ rtl/core/sld_outq.sv @@
// small output queue: takes up to two beats per cycle, hands out one while out_stall is low
// depends on sld_pkg
module sld_outq import sld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  parse_res_t res,
	output logic       full,
	output logic       out_valid,
	input  logic       out_stall,
	output beat_t      head
);

	beat_t              mem_q [OUTQ_DEPTH];
	logic [OUTQ_AW-1:0] wp_q;
	logic [OUTQ_AW-1:0] rp_q;
	logic [OUTQ_CW-1:0] cnt_q;
	logic [OUTQ_AW-1:0] wp_next;
	logic               pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = mem_q[rp_q];
	assign wp_next   = wp_q + OUTQ_AW'(1);
	// keep room for a two-beat sync burst
	assign full      = (cnt_q > OUTQ_CW'(OUTQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (res.count != 2'd0) begin
			mem_q[wp_q] <= res.b0;
		end
		if (res.count == 2'd2) begin
			mem_q[wp_next] <= res.b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OUTQ_AW'(res.count);
			if (pop) begin
				rp_q <= rp_q + OUTQ_AW'(1);
			end
			cnt_q <= cnt_q + OUTQ_CW'(res.count) - OUTQ_CW'(pop);
		end
	end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// self-checking testbench for sync_length_deframer_top: drives raw byte streams,
// predicts the framed beats in a scoreboard class and compares them as they leave
// depends on sld_pkg and the deframer rtl
module testbench import sld_pkg::*; ();

	localparam int unsigned CYCLE_LIMIT = 400000;

	typedef enum logic [2:0] {HUNT, LEN_LO, LEN_HI, PAYLOAD} deframe_phase_e;

	// predicts the beats of each accepted byte and holds them until they come out
	class frame_tracker;
		logic [7:0]     sync_a;
		logic [7:0]     sync_b;
		deframe_phase_e phase;
		bit             saw_a;
		logic [7:0]     len_lo;
		logic [15:0]    remaining;
		beat_t          pending[$];
		int unsigned    bytes_in;
		int unsigned    beats_out;
		int unsigned    frames_done;
		int unsigned    mismatches;

		function new();
			sync_a = SYNC_FIRST_RST;
			sync_b = SYNC_SECOND_RST;
			phase = HUNT;
			saw_a = 1'b0;
			len_lo = 8'h00;
			remaining = 16'h0000;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
			if (idx == CFG_SYNC_FIRST) begin
				sync_a = val;
			end else if (idx == CFG_SYNC_SECOND) begin
				sync_b = val;
			end
		endfunction

		function void add_expected(logic [7:0] data, logic first, logic last);
			beat_t e;
			e.data = data;
			e.first = first;
			e.last = last;
			pending.push_back(e);
		endfunction

		function void take_byte(logic [7:0] b);
			logic [15:0] len;
			bytes_in++;
			case (phase)
				LEN_LO: begin
					len_lo = b;
					phase = LEN_HI;
					add_expected(b, 1'b0, 1'b0);
				end
				LEN_HI: begin
					len = {b, len_lo};
					if (len == 16'h0000) begin
						// empty frame: the length high byte closes it
						phase = HUNT;
						remaining = 16'h0000;
						add_expected(b, 1'b0, 1'b1);
					end else begin
						phase = PAYLOAD;
						remaining = len;
						add_expected(b, 1'b0, 1'b0);
					end
				end
				PAYLOAD: begin
					if (remaining != 16'h0000)
						remaining = remaining - 16'h0001;
					if (remaining == 16'h0000) begin
						phase = HUNT;
						add_expected(b, 1'b0, 1'b1);
					end else begin
						add_expected(b, 1'b0, 1'b0);
					end
				end
				default: begin
					phase = HUNT;
					// second sync byte is tested first, so a run of equal bytes syncs on its second
					if (saw_a && b == sync_b) begin
						saw_a = 1'b0;
						phase = LEN_LO;
						add_expected(sync_a, 1'b1, 1'b0);
						add_expected(b, 1'b0, 1'b0);
					end else begin
						saw_a = (b == sync_a);
					end
				end
			endcase
		endfunction

		function void check_beat(beat_t got);
			beat_t exp;
			beats_out++;
			if (got.last === 1'b1)
				frames_done++;
			if (pending.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected beat: byte %02h first %0b last %0b",
						got.data, got.first, got.last);
				mismatches++;
			end else begin
				exp = pending.pop_front();
				if (got.data !== exp.data || got.first !== exp.first ||
					got.last !== exp.last) begin
					if (mismatches < 10)
						$display({"mismatch at beat %0d: expected byte %02h first %0b last %0b,",
							" got byte %02h first %0b last %0b"},
							beats_out, exp.data, exp.first, exp.last,
							got.data, got.first, got.last);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           in_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [7:0]           out_byte;
	logic                 frame_first;
	logic                 frame_last;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	frame_tracker tracker = new();
	logic [7:0]   stream[$];
	logic [7:0]   cur_first = SYNC_FIRST_RST;
	logic [7:0]   cur_second = SYNC_SECOND_RST;
	bit           sender_idles = 1'b0;
	bit           receiver_stalls = 1'b0;
	int unsigned  cycle_count = 0;
	int unsigned  settings_used = 1;

	sync_length_deframer_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.frame_first (frame_first),
		.frame_last  (frame_last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sample everything at the edge: config first, then outgoing beats, then incoming bytes
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				tracker.set_reg(cfg_index, cfg_data);
			if (out_valid && !out_stall)
				tracker.check_beat(beat_t'{data: out_byte, first: frame_first, last: frame_last});
			if (in_valid && !in_stall)
				tracker.take_byte(in_byte);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap(bit enabled);
		int r;
		if (!enabled)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 24);
	endfunction

	function automatic logic [7:0] noise_byte(bit avoid_first);
		logic [7:0] v;
		v = $urandom;
		if (avoid_first && v == cur_first)
			v = v ^ 8'h01;
		return v;
	endfunction

	// mostly good frames with random payload, plus overlapped syncs, broken syncs and noise
	function automatic void add_traffic(int n);
		int target;
		int r;
		int len;
		target = stream.size() + n;
		while (stream.size() < target) begin
			r = $urandom_range(0, 99);
			if (r < 70 || (cur_first == cur_second && r < 90)) begin
				repeat ($urandom_range(0, 2)) stream.push_back(noise_byte(1'b1));
				if (r >= 60 && cur_first != cur_second)
					stream.push_back(cur_first);
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
				stream.push_back(cur_first);
				stream.push_back(cur_second);
				stream.push_back(len[7:0]);
				stream.push_back(len[15:8]);
				repeat (len) stream.push_back(noise_byte(1'b0));
			end else if (r < 90) begin
				stream.push_back(cur_first);
				stream.push_back(cur_second ^ (8'h01 << $urandom_range(0, 7)));
			end else begin
				repeat ($urandom_range(1, 6)) stream.push_back(noise_byte(1'b0));
			end
		end
	endfunction

	task automatic send_stream();
		int gap;
		foreach (stream[i]) begin
			gap = pick_gap(sender_idles);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_byte <= stream[i];
			do @(posedge clk); while (in_stall);
		end
		stream.delete();
	endtask

	// wait until every predicted beat is out, then let a hunting byte settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_sync(logic [7:0] first, logic [7:0] second);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SYNC_FIRST;
		cfg_data <= first;
		@(posedge clk);
		cfg_index <= CFG_SYNC_SECOND;
		cfg_data <= second;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_first = first;
		cur_second = second;
		settings_used++;
	endtask

	initial begin
		int n;
		forever begin
			n = pick_gap(receiver_stalls);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	end

	initial begin
		logic [7:0] a;
		logic [7:0] b;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_byte <= 8'h00;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SYNC_FIRST;
		cfg_data <= 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sync word: noise, overlapped sync with empty frame, short frame
		stream = {8'h00, 8'hFF, 8'hEB, 8'hEB, 8'h90, 8'h00, 8'h00,
			8'h12, 8'hEB, 8'h90, 8'h02, 8'h00, 8'h55, 8'hAA};
		send_stream();
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
		add_traffic(150);
		// stop inside a frame so the next write lands mid-payload
		stream.push_back(cur_first);
		stream.push_back(cur_second);
		stream.push_back(8'h03);
		stream.push_back(8'h00);
		stream.push_back(8'hC3);
		send_stream();
		drain();

		write_sync(8'h00, 8'hFF);
		receiver_stalls = 1'b0;
		stream = {8'h3C, 8'h7E};
		add_traffic(150);
		send_stream();
		drain();

		// equal sync bytes: a run syncs on its second byte
		write_sync(8'h5A, 8'h5A);
		sender_idles = 1'b0;
		receiver_stalls = 1'b1;
		stream = {8'h11, 8'h5A, 8'h5A, 8'h02, 8'h00, 8'h5A, 8'h5A,
			8'h5A, 8'h5A, 8'h00, 8'h00};
		add_traffic(150);
		send_stream();
		drain();

		write_sync(8'hFF, 8'h00);
		receiver_stalls = 1'b0;
		add_traffic(150);
		send_stream();
		drain();

		a = $urandom;
		b = $urandom;
		if (a == b)
			b = ~a;
		write_sync(a, b);
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
		add_traffic(70);
		// one long frame so the length high byte carries weight
		stream.push_back(cur_first);
		stream.push_back(cur_second);
		stream.push_back(8'h00);
		stream.push_back(8'h01);
		repeat (256) stream.push_back(noise_byte(1'b0));
		add_traffic(70);
		send_stream();
		drain();

		write_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
		add_traffic(70);
		send_stream();
		drain();
		repeat (8) @(posedge clk);

		if (tracker.pending.size() != 0)
			$display("%0d expected beats never came out", tracker.pending.size());
		$display("run covered %0d bytes in and %0d beats out, %0d frames closed",
			tracker.bytes_in, tracker.beats_out, tracker.frames_done);
		$display("across %0d sync word settings with mixed idle and stall patterns, %0d mismatches",
			settings_used, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ sync_length_deframer_top.f @@
rtl/core/sld_pkg.sv
rtl/core/sld_parser.sv
rtl/core/sld_outq.sv
rtl/core/sync_length_deframer_top.sv
dv/testbench.sv
